### rtl/cstrip_pkg.sv
// Shared types and constants for the comment stripper.
// Used by cstrip_front, cstrip_fifo, cstrip_back and comment_stripper.
`default_nettype none

package cstrip_pkg;

  // Characters that matter to the scanner
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Most results one input item can cause
  localparam int unsigned MAX_RES = 3;

  // Entries in the queue between front and back
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_BLOCK = 2'd2,
    MODE_ERR   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_SEG_END = 2'd1,
    KIND_TOKEN   = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  // One result without its tag
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
  } ent_t;

  // All results of one item; at most one of them is a token, so the
  // tag travels alongside once per bundle
  typedef struct packed {
    logic [1:0]           cnt;
    ent_t [MAX_RES-1:0]   ent;
  } bundle_t;

endpackage

`default_nettype wire

### rtl/comment_stripper.sv
// Top level of the C-style comment stripper.
// Instantiates cstrip_front, cstrip_fifo and cstrip_back; uses cstrip_pkg.
//
// Source characters (with a last-of-token mark) and opaque tokens come in
// through a push/full port; literal characters, segment ends, opaque tokens
// and a sticky error come out through an empty/pop port, oldest first, with
// run_last_o set on the final result of each input item. An item is taken
// every cycle while the two-bundle queue between front and back has room;
// results leave at one per cycle while pop is held, so an item with more than
// one result holds the output until all of its results are popped, and the
// sustained rate is set by the result count of each item (one to three
// results, none for items that produce nothing). A stray block-comment
// close puts the block in an error state that drops all input until reset.
`default_nettype none

module comment_stripper #(
  parameter int unsigned TAG_WIDTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic                    is_token_i,
  input  wire logic [7:0]              char_byte_i,
  input  wire logic                    token_last_i,
  input  wire logic [TAG_WIDTH-1:0]    token_tag_i,
  output logic                         empty,
  input  wire logic                    pop,
  output logic [1:0]                   kind_o,
  output logic [7:0]                   out_byte_o,
  output logic [TAG_WIDTH-1:0]         out_tag_o,
  output logic                         run_last_o
);

  logic                 accept;
  logic                 f_push;
  cstrip_pkg::bundle_t  f_bnd;
  logic [TAG_WIDTH-1:0] f_tag;
  logic                 q_empty, q_pop;
  cstrip_pkg::bundle_t  q_bnd;
  logic [TAG_WIDTH-1:0] q_tag;

  assign accept = push && !full;

  cstrip_front #(.TAG_WIDTH(TAG_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .is_token_i   (is_token_i),
    .char_byte_i  (char_byte_i),
    .token_last_i (token_last_i),
    .token_tag_i  (token_tag_i),
    .push_o       (f_push),
    .bnd_o        (f_bnd),
    .tag_o        (f_tag)
  );

  cstrip_fifo #(.TAG_WIDTH(TAG_WIDTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .bnd_i   (f_bnd),
    .tag_i   (f_tag),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .bnd_o   (q_bnd),
    .tag_o   (q_tag)
  );

  cstrip_back #(.TAG_WIDTH(TAG_WIDTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_bnd_i    (q_bnd),
    .q_tag_i    (q_tag),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .kind_o     (kind_o),
    .out_byte_o (out_byte_o),
    .out_tag_o  (out_tag_o),
    .run_last_o (run_last_o)
  );

endmodule

`default_nettype wire

### rtl/cstrip_front.sv
// Front end: accepts items, tracks comment state and the held character,
// and builds the bundle of results for each item. Depends on cstrip_pkg.
`default_nettype none

module cstrip_front #(
  parameter int unsigned TAG_WIDTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire logic                    is_token_i,
  input  wire logic [7:0]              char_byte_i,
  input  wire logic                    token_last_i,
  input  wire logic [TAG_WIDTH-1:0]    token_tag_i,
  output logic                         push_o,
  output cstrip_pkg::bundle_t          bnd_o,
  output logic [TAG_WIDTH-1:0]         tag_o
);

  cstrip_pkg::mode_e mode_q, mode_d;
  logic              pv_q, pv_d;
  logic [7:0]        pc_q, pc_d;
  logic              seg_q, seg_d;

  // Next state and results, written in the order the items are scanned
  always_comb begin
    logic [1:0] n;
    logic       consumed;
    logic       pair;
    logic       c_hold;
    n        = '0;
    consumed = 1'b0;
    pair     = 1'b0;
    c_hold   = 1'b0;
    mode_d   = mode_q;
    pv_d     = pv_q;
    pc_d     = pc_q;
    seg_d    = seg_q;
    bnd_o    = '0;
    tag_o    = token_tag_i;

    if (mode_q != cstrip_pkg::MODE_ERR) begin
      if (is_token_i) begin
        // held char flushed alone, open run closed, then the token
        if (pv_d) begin
          pv_d = 1'b0;
          if (mode_d == cstrip_pkg::MODE_NONE) begin
            bnd_o.ent[n].kind = cstrip_pkg::KIND_CHAR;
            bnd_o.ent[n].data = pc_q;
            n     = n + 2'd1;
            seg_d = 1'b1;
          end
        end
        if (seg_d) begin
          bnd_o.ent[n].kind = cstrip_pkg::KIND_SEG_END;
          n     = n + 2'd1;
          seg_d = 1'b0;
        end
        if (mode_d == cstrip_pkg::MODE_NONE) begin
          bnd_o.ent[n].kind = cstrip_pkg::KIND_TOKEN;
          n = n + 2'd1;
        end
      end else begin
        if (pv_d) begin
          pv_d = 1'b0;
          pair = ((pc_q == cstrip_pkg::CH_SLASH) &&
                  ((char_byte_i == cstrip_pkg::CH_STAR) ||
                   (char_byte_i == cstrip_pkg::CH_SLASH))) ||
                 ((pc_q == cstrip_pkg::CH_STAR) &&
                  (char_byte_i == cstrip_pkg::CH_SLASH));
          if (pair) begin
            consumed = 1'b1;
            if (seg_d) begin
              bnd_o.ent[n].kind = cstrip_pkg::KIND_SEG_END;
              n     = n + 2'd1;
              seg_d = 1'b0;
            end
            if (mode_d == cstrip_pkg::MODE_NONE) begin
              if (pc_q == cstrip_pkg::CH_SLASH) begin
                if (char_byte_i == cstrip_pkg::CH_STAR) begin
                  mode_d = cstrip_pkg::MODE_BLOCK;
                end else begin
                  mode_d = cstrip_pkg::MODE_LINE;
                end
              end else begin
                // stray block close: sticky error
                bnd_o.ent[n].kind = cstrip_pkg::KIND_ERROR;
                n      = n + 2'd1;
                mode_d = cstrip_pkg::MODE_ERR;
              end
            end else if (mode_d == cstrip_pkg::MODE_BLOCK) begin
              if (pc_q == cstrip_pkg::CH_STAR) begin
                mode_d = cstrip_pkg::MODE_NONE;
              end
            end
          end else if (mode_d == cstrip_pkg::MODE_NONE) begin
            bnd_o.ent[n].kind = cstrip_pkg::KIND_CHAR;
            bnd_o.ent[n].data = pc_q;
            n     = n + 2'd1;
            seg_d = 1'b1;
          end
        end

        if (!consumed) begin
          c_hold = ((char_byte_i == cstrip_pkg::CH_SLASH) ||
                    (char_byte_i == cstrip_pkg::CH_STAR)) && !token_last_i;
          if (c_hold) begin
            pv_d = 1'b1;
            pc_d = char_byte_i;
          end else begin
            if (char_byte_i == cstrip_pkg::CH_NEWLINE) begin
              if (seg_d) begin
                bnd_o.ent[n].kind = cstrip_pkg::KIND_SEG_END;
                n     = n + 2'd1;
                seg_d = 1'b0;
              end
              if (mode_d == cstrip_pkg::MODE_LINE) begin
                mode_d = cstrip_pkg::MODE_NONE;
              end
            end else if (mode_d == cstrip_pkg::MODE_NONE) begin
              bnd_o.ent[n].kind = cstrip_pkg::KIND_CHAR;
              bnd_o.ent[n].data = char_byte_i;
              n     = n + 2'd1;
              seg_d = 1'b1;
            end
            if (token_last_i && seg_d) begin
              bnd_o.ent[n].kind = cstrip_pkg::KIND_SEG_END;
              n     = n + 2'd1;
              seg_d = 1'b0;
            end
          end
        end
      end
    end

    bnd_o.cnt = n;
    push_o    = accept_i && (n != 2'd0);
  end

  // Scanner state, updated on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cstrip_pkg::MODE_NONE;
      pv_q   <= 1'b0;
      pc_q   <= '0;
      seg_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      pv_q   <= pv_d;
      pc_q   <= pc_d;
      seg_q  <= seg_d;
    end
  end

endmodule

`default_nettype wire

### rtl/cstrip_fifo.sv
// Short queue of result bundles between front and back.
// Depends on cstrip_pkg for the bundle type and depth.
`default_nettype none

module cstrip_fifo #(
  parameter int unsigned TAG_WIDTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire cstrip_pkg::bundle_t     bnd_i,
  input  wire logic [TAG_WIDTH-1:0]    tag_i,
  output logic                         full_o,
  input  wire logic                    pop_i,
  output logic                         empty_o,
  output cstrip_pkg::bundle_t          bnd_o,
  output logic [TAG_WIDTH-1:0]         tag_o
);

  localparam int unsigned PW = (cstrip_pkg::QDEPTH > 1) ? $clog2(cstrip_pkg::QDEPTH) : 1;
  localparam int unsigned CW = $clog2(cstrip_pkg::QDEPTH + 1);

  cstrip_pkg::bundle_t     bnd_mem [cstrip_pkg::QDEPTH];
  logic [TAG_WIDTH-1:0]    tag_mem [cstrip_pkg::QDEPTH];
  logic [PW-1:0]           wp_q, rp_q;
  logic [CW-1:0]           cnt_q;
  logic                    do_push, do_pop;

  assign full_o  = (cnt_q == CW'(cstrip_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign bnd_o   = bnd_mem[rp_q];
  assign tag_o   = tag_mem[rp_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      bnd_mem[wp_q] <= bnd_i;
      tag_mem[wp_q] <= tag_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(cstrip_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(cstrip_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/cstrip_back.sv
// Back end: holds one bundle and hands its results out one per transfer.
// Depends on cstrip_pkg for the bundle and kind types.
`default_nettype none

module cstrip_back #(
  parameter int unsigned TAG_WIDTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_empty_i,
  input  wire cstrip_pkg::bundle_t     q_bnd_i,
  input  wire logic [TAG_WIDTH-1:0]    q_tag_i,
  output logic                         q_pop_o,
  input  wire logic                    pop_i,
  output logic                         empty_o,
  output logic [1:0]                   kind_o,
  output logic [7:0]                   out_byte_o,
  output logic [TAG_WIDTH-1:0]         out_tag_o,
  output logic                         run_last_o
);

  cstrip_pkg::bundle_t  cur_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic                 val_q;
  logic [1:0]           idx_q;
  logic                 take, is_last;
  cstrip_pkg::ent_t     ent;

  assign ent     = cur_q.ent[idx_q];
  assign is_last = (idx_q == (cur_q.cnt - 2'd1));
  assign take    = pop_i && val_q;
  assign q_pop_o = !q_empty_i && (!val_q || (take && is_last));

  // Result ports
  assign empty_o    = !val_q;
  assign kind_o     = ent.kind;
  assign out_byte_o = ent.data;
  assign out_tag_o  = (ent.kind == cstrip_pkg::KIND_TOKEN) ? tag_q : '0;
  assign run_last_o = is_last;

  // Bundle payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_bnd_i;
      tag_q <= q_tag_i;
    end
  end

  // Current bundle valid and result index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= 1'b0;
      idx_q <= '0;
    end else if (q_pop_o) begin
      val_q <= 1'b1;
      idx_q <= '0;
    end else if (take) begin
      if (is_last) begin
        val_q <= 1'b0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for comment_stripper: directed and random source streams.
// Depends on cstrip_pkg (characters, mode and result kinds) and the RTL top level.
// Results are predicted per accepted item and checked in order at the result port.
`default_nettype none

module testbench;

  // One input item as driven on the push side
  typedef struct packed {
    logic        is_tok;
    logic [7:0]  ch;
    logic        last;
    logic [15:0] tag;
  } src_item_t;

  // One result as seen on the pop side
  typedef struct packed {
    cstrip_pkg::kind_e kind;
    logic [7:0]        data;
    logic [15:0]       tag;
    logic              run_last;
  } strip_res_t;

  // Scanner state: comment mode, held '/' or '*', open literal run
  typedef struct packed {
    cstrip_pkg::mode_e mode;
    logic              held_v;
    logic [7:0]        held_ch;
    logic              run_open;
  } scan_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        is_token_i = 1'b0;
  logic [7:0]  char_byte_i = 8'h00;
  logic        token_last_i = 1'b0;
  logic [15:0] token_tag_i = 16'h0000;
  logic        full;
  logic        empty;
  logic [1:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic [15:0] out_tag_o;
  logic        run_last_o;

  src_item_t   src_q[$];      // items waiting to be offered
  strip_res_t  due_q[$];      // results predicted, not yet popped
  scan_state_t gen_st = '0;   // scanner state as seen by the stimulus generator
  scan_state_t acc_st = '0;   // scanner state over accepted items
  src_item_t   cur_item = '0;
  int          gen_cnt = 0;
  int          taken_cnt = 0;
  int          err_cnt = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_cnt = 0;
  logic        hold_off = 1'b0;
  logic        hold_done = 1'b0;
  logic        calm = 1'b0;

  comment_stripper DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .is_token_i   (is_token_i),
    .char_byte_i  (char_byte_i),
    .token_last_i (token_last_i),
    .token_tag_i  (token_tag_i),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .out_tag_o    (out_tag_o),
    .run_last_o   (run_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void add_res(ref strip_res_t q[$], input cstrip_pkg::kind_e k,
                                  input logic [7:0] d, input logic [15:0] t);
    strip_res_t r;
    r.kind     = k;
    r.data     = d;
    r.tag      = t;
    r.run_last = 1'b0;
    q = {q, r};
  endfunction

  function automatic void close_run(ref scan_state_t st, ref strip_res_t q[$]);
    if (st.run_open) begin
      add_res(q, cstrip_pkg::KIND_SEG_END, 8'h00, 16'h0000);
      st.run_open = 1'b0;
    end
  endfunction

  // A character that is not part of a pair
  function automatic void plain_char(ref scan_state_t st, ref strip_res_t q[$],
                                     input logic [7:0] c);
    if (c == cstrip_pkg::CH_NEWLINE) begin
      close_run(st, q);
      if (st.mode == cstrip_pkg::MODE_LINE) st.mode = cstrip_pkg::MODE_NONE;
    end else if (st.mode == cstrip_pkg::MODE_NONE) begin
      add_res(q, cstrip_pkg::KIND_CHAR, c, 16'h0000);
      st.run_open = 1'b1;
    end
  endfunction

  // Results of one item; q is cleared first
  function automatic void strip_predict(ref scan_state_t st, input src_item_t it,
                                        ref strip_res_t q[$]);
    logic taken;
    q.delete();
    if (st.mode == cstrip_pkg::MODE_ERR) return;
    if (it.is_tok) begin
      // a token ends the unparsed token: flush the held char, close the run
      if (st.held_v) begin
        st.held_v = 1'b0;
        plain_char(st, q, st.held_ch);
      end
      close_run(st, q);
      if (st.mode == cstrip_pkg::MODE_NONE)
        add_res(q, cstrip_pkg::KIND_TOKEN, 8'h00, it.tag);
    end else begin
      taken = 1'b0;
      if (st.held_v) begin
        st.held_v = 1'b0;
        if ((st.held_ch == cstrip_pkg::CH_SLASH &&
             (it.ch == cstrip_pkg::CH_STAR || it.ch == cstrip_pkg::CH_SLASH)) ||
            (st.held_ch == cstrip_pkg::CH_STAR && it.ch == cstrip_pkg::CH_SLASH)) begin
          taken = 1'b1;
          close_run(st, q);
          if (st.mode == cstrip_pkg::MODE_NONE) begin
            if (st.held_ch == cstrip_pkg::CH_SLASH) begin
              st.mode = (it.ch == cstrip_pkg::CH_STAR) ? cstrip_pkg::MODE_BLOCK
                                                       : cstrip_pkg::MODE_LINE;
            end else begin
              // stray block close: sticky error
              add_res(q, cstrip_pkg::KIND_ERROR, 8'h00, 16'h0000);
              st.mode = cstrip_pkg::MODE_ERR;
            end
          end else if (st.mode == cstrip_pkg::MODE_BLOCK &&
                       st.held_ch == cstrip_pkg::CH_STAR) begin
            st.mode = cstrip_pkg::MODE_NONE;
          end
          if (it.last && st.mode != cstrip_pkg::MODE_ERR) close_run(st, q);
        end else begin
          plain_char(st, q, st.held_ch);
        end
      end
      if (!taken) begin
        if ((it.ch == cstrip_pkg::CH_SLASH || it.ch == cstrip_pkg::CH_STAR) &&
            !it.last) begin
          st.held_v  = 1'b1;
          st.held_ch = it.ch;
        end else begin
          plain_char(st, q, it.ch);
          if (it.last) close_run(st, q);
        end
      end
    end
    if (q.size() > 0) q[q.size()-1].run_last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic src_item_t chr(input logic [7:0] c, input logic l);
    src_item_t it;
    it.is_tok = 1'b0;
    it.ch     = c;
    it.last   = l;
    it.tag    = 16'($urandom);   // ignored field, keep it noisy
    return it;
  endfunction

  function automatic src_item_t tok(input logic [15:0] t);
    src_item_t it;
    it.is_tok = 1'b1;
    it.ch     = 8'($urandom);
    it.last   = 1'($urandom);
    it.tag    = t;
    return it;
  endfunction

  // Mostly the characters that steer the scanner, else any byte
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return cstrip_pkg::CH_SLASH;
      2, 3:    return cstrip_pkg::CH_STAR;
      4:       return cstrip_pkg::CH_NEWLINE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Queue an item; with avoid_err a stray close is turned into a plain 'x'
  function automatic void add_item(input src_item_t it, input bit avoid_err);
    scan_state_t trial;
    strip_res_t  scratch[$];
    trial = gen_st;
    strip_predict(trial, it, scratch);
    if (avoid_err && trial.mode == cstrip_pkg::MODE_ERR) begin
      it.ch = 8'h78;
      trial = gen_st;
      strip_predict(trial, it, scratch);
    end
    gen_st = trial;
    src_q = {src_q, it};
    gen_cnt++;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int   len;
    logic cut;

    // directed: field extremes, runs, pairs in every mode, missing last mark
    add_item(chr(8'h61, 1'b0), 1'b1);                   // 'a'
    add_item(chr(8'hFF, 1'b0), 1'b1);
    add_item(chr(8'h00, 1'b1), 1'b1);
    add_item(chr(cstrip_pkg::CH_SLASH, 1'b1), 1'b1);    // last char: not held
    add_item(chr(cstrip_pkg::CH_STAR, 1'b1), 1'b1);
    add_item(chr(8'h78, 1'b0), 1'b1);                   // 'x'
    add_item(chr(cstrip_pkg::CH_NEWLINE, 1'b0), 1'b1);  // newline closes the run
    add_item(chr(8'h79, 1'b0), 1'b1);                   // 'y'
    add_item(chr(cstrip_pkg::CH_SLASH, 1'b0), 1'b1);    // held
    add_item(tok(16'hFFFF), 1'b1);                      // flush held, close run, token
    add_item(chr(8'h71, 1'b0), 1'b1);                   // 'q'
    add_item(tok(16'h0000), 1'b1);                      // run open without last mark
    add_item(chr(cstrip_pkg::CH_SLASH, 1'b0), 1'b1);    // block comment opens
    add_item(chr(cstrip_pkg::CH_STAR, 1'b0), 1'b1);
    add_item(chr(cstrip_pkg::CH_SLASH, 1'b0), 1'b1);    // line opener inside block
    add_item(chr(cstrip_pkg::CH_SLASH, 1'b1), 1'b1);
    add_item(tok(16'h5A5A), 1'b1);                      // dropped inside block
    add_item(chr(cstrip_pkg::CH_STAR, 1'b0), 1'b1);     // block closes
    add_item(chr(cstrip_pkg::CH_SLASH, 1'b1), 1'b1);
    add_item(chr(cstrip_pkg::CH_SLASH, 1'b0), 1'b1);    // line comment opens
    add_item(chr(cstrip_pkg::CH_SLASH, 1'b0), 1'b1);
    add_item(chr(cstrip_pkg::CH_STAR, 1'b0), 1'b1);     // stray close inside line comment
    add_item(chr(cstrip_pkg::CH_SLASH, 1'b0), 1'b1);
    add_item(chr(cstrip_pkg::CH_NEWLINE, 1'b1), 1'b1);  // line comment ends
    add_item(chr(8'h6B, 1'b1), 1'b1);                   // 'k'

    // random: mostly well-formed text, comments and tokens with random content
    while (gen_cnt < 142) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          len = $urandom_range(1, 6);
          cut = ($urandom_range(0, 7) == 0);
          for (int i = 0; i < len; i++)
            add_item(chr(pick_char(), (i == len - 1) && !cut), 1'b1);
        end
        4, 5: begin
          add_item(chr(cstrip_pkg::CH_SLASH, 1'b0), 1'b1);
          add_item(chr(cstrip_pkg::CH_STAR, 1'b0), 1'b1);
          len = $urandom_range(0, 4);
          for (int i = 0; i < len; i++)
            add_item(chr(pick_char(), 1'($urandom_range(0, 3) == 0)), 1'b1);
          add_item(chr(cstrip_pkg::CH_STAR, 1'b0), 1'b1);
          add_item(chr(cstrip_pkg::CH_SLASH, 1'b1), 1'b1);
        end
        6, 7: begin
          add_item(chr(cstrip_pkg::CH_SLASH, 1'b0), 1'b1);
          add_item(chr(cstrip_pkg::CH_SLASH, 1'b0), 1'b1);
          len = $urandom_range(0, 4);
          for (int i = 0; i < len; i++)
            add_item(chr(pick_char(), 1'b0), 1'b1);
          add_item(chr(cstrip_pkg::CH_NEWLINE, 1'b1), 1'b1);
        end
        default: add_item(tok(16'($urandom)), 1'b1);
      endcase
    end

    // leave any comment, then a stray close with an open run, then dead input
    add_item(tok(16'($urandom)), 1'b1);
    if (gen_st.mode == cstrip_pkg::MODE_BLOCK) begin
      add_item(chr(cstrip_pkg::CH_STAR, 1'b0), 1'b1);
      add_item(chr(cstrip_pkg::CH_SLASH, 1'b1), 1'b1);
    end else if (gen_st.mode == cstrip_pkg::MODE_LINE) begin
      add_item(chr(cstrip_pkg::CH_NEWLINE, 1'b1), 1'b1);
    end
    add_item(chr(8'h61, 1'b0), 1'b0);
    add_item(chr(cstrip_pkg::CH_STAR, 1'b0), 1'b0);
    add_item(chr(cstrip_pkg::CH_SLASH, 1'b0), 1'b0);
    add_item(chr(8'h62, 1'b1), 1'b0);
    add_item(tok(16'h8001), 1'b0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (src_q.size() != 0 || push) @(posedge clk_i);
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, predicts on every transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : drive_items
    strip_res_t step_q[$];
    if (rst_ni) begin
      if (push && !full) begin
        strip_predict(acc_st, cur_item, step_q);
        due_q = {due_q, step_q};
        taken_cnt <= taken_cnt + 1;
      end
      calm <= (src_q.size() < 40);
      // an offered item stays put until it transfers
      if (!(push && full)) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (src_q.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 13);
          push <= 1'b0;
        end else if (src_q.size() != 0) begin
          cur_item = src_q.pop_front();
          is_token_i   <= cur_item.is_tok;
          char_byte_i  <= cur_item.ch;
          token_last_i <= cur_item.last;
          token_tag_i  <= cur_item.tag;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // One long receiver stall so the block backs up and raises full
  always @(posedge clk_i) begin : long_stall
    if (rst_ni && taken_cnt >= 40 && !hold_done) begin
      if (hold_cnt == 79) begin
        hold_done <= 1'b1;
        hold_off  <= 1'b0;
      end else begin
        hold_cnt <= hold_cnt + 1;
        hold_off <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every popped result against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_results
    strip_res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (due_q.size() == 0) begin
          if (err_cnt < 10)
            $display("unexpected result: kind %0d byte %02h tag %04h last %0d",
                     kind_o, out_byte_o, out_tag_o, run_last_o);
          err_cnt++;
        end else begin
          want = due_q.pop_front();
          if (kind_o !== want.kind || out_byte_o !== want.data ||
              out_tag_o !== want.tag || run_last_o !== want.run_last) begin
            if (err_cnt < 10)
              $display("mismatch: want %0d/%02h/%04h/%0d got %0d/%02h/%04h/%0d",
                       want.kind, want.data, want.tag, want.run_last,
                       kind_o, out_byte_o, out_tag_o, run_last_o);
            err_cnt++;
          end
        end
      end
      // receiver idling: long stall, random bursts, none near the end
      if (hold_off) begin
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 13);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
